// ===== src/vdrm_pkg.sv =====
// ----------------------------------------------------------------------------
// vdrm_pkg
// Shared sizes, operation codes and helpers for the virtqueue descriptor
// ring manager.
// ----------------------------------------------------------------------------
package vdrm_pkg;

  // Largest queue the block supports; sets table and ring depth
  localparam int MAX_DESCRIPTORS = 256;
  // Descriptor number / ring position width
  localparam int IDX_W = $clog2(MAX_DESCRIPTORS);
  // Count width: holds 0 .. MAX_DESCRIPTORS
  localparam int CNT_W = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int ADDED_W = 16;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_ALLOC     = 2'd0,
    KIND_FREE      = 2'd1,
    KIND_ADD_AVAIL = 2'd2,
    KIND_ADD_USED  = 2'd3
  } kind_t;

  // Map a list pointer onto a table row; out-of-range pointers fold to row 0
  function automatic logic [IDX_W-1:0] slot(input logic [CNT_W-1:0] ptr);
    logic [IDX_W-1:0] res;
    res = (ptr < CNT_W'(MAX_DESCRIPTORS)) ? ptr[IDX_W-1:0] : '0;
    return res;
  endfunction

  // Advance a ring position, wrapping at the queue size
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos,
                                                 input logic [CNT_W-1:0] size);
    logic [CNT_W-1:0] n;
    n = {1'b0, pos} + CNT_W'(1);
    return (n >= size) ? '0 : n[IDX_W-1:0];
  endfunction

endpackage

// ===== src/vdrm_if.sv =====
// ----------------------------------------------------------------------------
// vdrm_req_if / vdrm_rsp_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface vdrm_req_if;
  logic                          valid;
  logic                          ready;
  vdrm_pkg::kind_t               kind;
  logic [vdrm_pkg::DATA_W-1:0]   buf_addr;
  logic [vdrm_pkg::DATA_W-1:0]   buf_len;
  logic [vdrm_pkg::IDX_W-1:0]    desc_index;

  modport source (output valid, kind, buf_addr, buf_len, desc_index, input ready);
  modport sink   (input valid, kind, buf_addr, buf_len, desc_index, output ready);
endinterface

interface vdrm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vdrm_pkg::IDX_W-1:0]    alloc_index;
  logic                          out_of_descriptors;
  logic [vdrm_pkg::CNT_W-1:0]    free_count;
  logic [vdrm_pkg::IDX_W-1:0]    avail_position;
  logic [vdrm_pkg::IDX_W-1:0]    used_position;

  modport source (output valid, alloc_index, out_of_descriptors, free_count,
                  avail_position, used_position, input ready);
  modport sink   (input valid, alloc_index, out_of_descriptors, free_count,
                  avail_position, used_position, output ready);
endinterface

// ===== src/vdrm_ram.sv =====
// ----------------------------------------------------------------------------
// vdrm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vdrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/virtqueue_descriptor_ring_manager_top.sv =====
// ----------------------------------------------------------------------------
// virtqueue_descriptor_ring_manager_top
// Split virtqueue manager: descriptor table with threaded free list,
// available ring and used ring.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (valid/ready) carries one operation per beat: alloc, free,
//          add-avail or add-used, with buffer address, length and index.
//   out_ch (valid/ready) returns exactly one result beat per operation:
//          allocated index, out-of-descriptors flag, free count and both
//          ring positions after the operation.
//   cfg_we/cfg_wdata write the queue size (1..256; 0 counts as 1, larger
//          values clamp to 256). A write rebuilds the free list as
//          0..size-1 and clears both ring positions. Write only when idle.
// Timing: an operation is accepted in the idle state and executed in the exec
//   state, which loads the result register; a full result register holds exec.
//   No new operation is accepted until the current one has executed: alloc
//   needs the registered link table read of the free list head to move it.
// Reset: queue size 256, full free list, ring positions zero. The link table
//   needs no clearing pass: per-row valid bits make unwritten rows read as
//   their rebuilt value.
// Stall: a waiting result does not block the next accept; execution of that
//   next operation holds until the result register drains.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_ring_manager_top (
  input  logic                        clk,
  input  logic                        rst_n,
  vdrm_req_if.sink                    in_ch,
  vdrm_rsp_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [vdrm_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int IDX_W = vdrm_pkg::IDX_W;
  localparam int CNT_W = vdrm_pkg::CNT_W;
  localparam int DATA_W = vdrm_pkg::DATA_W;
  localparam int MAXD = vdrm_pkg::MAX_DESCRIPTORS;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                       state_r;
  vdrm_pkg::kind_t              kind_r;
  logic [DATA_W-1:0]            addr_r;
  logic [DATA_W-1:0]            len_r;
  logic [IDX_W-1:0]             idx_r;
  logic [IDX_W-1:0]             head_slot_r;
  logic                         rd_vld_r;

  logic [CNT_W-1:0]             qsize_r;
  logic [CNT_W-1:0]             head_r;
  logic [CNT_W-1:0]             total_r;
  logic [IDX_W-1:0]             avail_r;
  logic [IDX_W-1:0]             used_r;
  logic [vdrm_pkg::ADDED_W-1:0] added_r;
  logic [MAXD-1:0]              link_vld_r;

  logic                         out_valid_r;
  logic [IDX_W-1:0]             out_alloc_r;
  logic                         out_empty_r;
  logic [CNT_W-1:0]             out_free_r;
  logic [IDX_W-1:0]             out_avail_r;
  logic [IDX_W-1:0]             out_used_r;

  logic                         in_fire;
  logic                         exec_go;
  logic [IDX_W-1:0]             head_slot;
  logic [CNT_W-1:0]             link_rd_data;
  logic [CNT_W-1:0]             link_dflt;
  logic [CNT_W-1:0]             link_val;
  logic [CNT_W-1:0]             cfg_size;

  logic                         alloc_ok;
  logic                         free_ok;
  logic                         empty_nxt;
  logic [IDX_W-1:0]             given_nxt;
  logic [CNT_W-1:0]             head_nxt;
  logic [CNT_W-1:0]             total_nxt;
  logic [IDX_W-1:0]             avail_nxt;
  logic [IDX_W-1:0]             used_nxt;

  // Handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign exec_go     = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid              = out_valid_r;
  assign out_ch.alloc_index        = out_alloc_r;
  assign out_ch.out_of_descriptors = out_empty_r;
  assign out_ch.free_count         = out_free_r;
  assign out_ch.avail_position     = out_avail_r;
  assign out_ch.used_position      = out_used_r;

  // Head row of the free list, read at accept
  assign head_slot = vdrm_pkg::slot(head_r);

  // Clamp a written queue size to 1..MAX
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_size = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(MAXD)) begin
      cfg_size = CNT_W'(MAXD);
    end else begin
      cfg_size = cfg_wdata;
    end
  end

  // Link of the head row: RAM data if written since rebuild, else rebuilt value
  assign link_dflt = ({1'b0, head_slot_r} == qsize_r - CNT_W'(1)) ?
                     qsize_r : ({1'b0, head_slot_r} + CNT_W'(1));
  assign link_val  = rd_vld_r ? link_rd_data : link_dflt;

  // Operation results
  always_comb begin
    alloc_ok  = (kind_r == vdrm_pkg::KIND_ALLOC) && (total_r != '0);
    free_ok   = (kind_r == vdrm_pkg::KIND_FREE) && ({1'b0, idx_r} < qsize_r) &&
                (total_r < qsize_r);
    empty_nxt = (kind_r == vdrm_pkg::KIND_ALLOC) && (total_r == '0);
    given_nxt = '0;
    head_nxt  = head_r;
    total_nxt = total_r;
    avail_nxt = avail_r;
    used_nxt  = used_r;
    case (kind_r)
      vdrm_pkg::KIND_ALLOC: begin
        if (alloc_ok) begin
          given_nxt = head_slot_r;
          head_nxt  = link_val;
          total_nxt = total_r - CNT_W'(1);
        end
      end
      vdrm_pkg::KIND_FREE: begin
        if (free_ok) begin
          head_nxt  = {1'b0, idx_r};
          total_nxt = total_r + CNT_W'(1);
        end
      end
      vdrm_pkg::KIND_ADD_AVAIL: avail_nxt = vdrm_pkg::ring_next(avail_r, qsize_r);
      default:                  used_nxt  = vdrm_pkg::ring_next(used_r, qsize_r);
    endcase
  end

  // Link table: free writes the old head into the freed row
  vdrm_ram #(.WIDTH(CNT_W), .DEPTH(MAXD)) u_link_ram (
    .clk     (clk),
    .wr_en   (exec_go && free_ok),
    .wr_addr (idx_r),
    .wr_data (head_r),
    .rd_addr (head_slot),
    .rd_data (link_rd_data)
  );

  // Descriptor buffer address and length, stored on alloc
  vdrm_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAXD)) u_desc_ram (
    .clk     (clk),
    .wr_en   (exec_go && alloc_ok),
    .wr_addr (head_slot_r),
    .wr_data ({addr_r, len_r}),
    .rd_addr (idx_r),
    .rd_data ()
  );

  // Available ring ids
  vdrm_ram #(.WIDTH(IDX_W), .DEPTH(MAXD)) u_avail_ram (
    .clk     (clk),
    .wr_en   (exec_go && (kind_r == vdrm_pkg::KIND_ADD_AVAIL)),
    .wr_addr (avail_r),
    .wr_data (idx_r),
    .rd_addr (avail_r),
    .rd_data ()
  );

  // Used ring ids and lengths
  vdrm_ram #(.WIDTH(IDX_W + DATA_W), .DEPTH(MAXD)) u_used_ram (
    .clk     (clk),
    .wr_en   (exec_go && (kind_r == vdrm_pkg::KIND_ADD_USED)),
    .wr_addr (used_r),
    .wr_data ({idx_r, len_r}),
    .rd_addr (used_r),
    .rd_data ()
  );

  // Request capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= in_ch.kind;
      addr_r      <= in_ch.buf_addr;
      len_r       <= in_ch.buf_len;
      idx_r       <= in_ch.desc_index;
      head_slot_r <= head_slot;
      rd_vld_r    <= link_vld_r[head_slot];
    end
  end

  // Control FSM, queue state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qsize_r     <= CNT_W'(MAXD);
      head_r      <= '0;
      total_r     <= CNT_W'(MAXD);
      avail_r     <= '0;
      used_r      <= '0;
      added_r     <= '0;
      link_vld_r  <= '0;
      out_valid_r <= 1'b0;
      out_alloc_r <= '0;
      out_empty_r <= 1'b0;
      out_free_r  <= '0;
      out_avail_r <= '0;
      out_used_r  <= '0;
    end else begin
      // Drained result with no new one behind it
      if (out_valid_r && out_ch.ready && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_r     <= ST_IDLE;
            head_r      <= head_nxt;
            total_r     <= total_nxt;
            avail_r     <= avail_nxt;
            used_r      <= used_nxt;
            if (kind_r == vdrm_pkg::KIND_ADD_AVAIL) begin
              added_r <= added_r + vdrm_pkg::ADDED_W'(1);
            end
            if (free_ok) begin
              link_vld_r[idx_r] <= 1'b1;
            end
            out_valid_r <= 1'b1;
            out_alloc_r <= given_nxt;
            out_empty_r <= empty_nxt;
            out_free_r  <= total_nxt;
            out_avail_r <= avail_nxt;
            out_used_r  <= used_nxt;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // Queue size write: rebuild the free list, clear ring positions
      if (cfg_we) begin
        qsize_r    <= cfg_size;
        head_r     <= '0;
        total_r    <= cfg_size;
        avail_r    <= '0;
        used_r     <= '0;
        added_r    <= '0;
        link_vld_r <= '0;
      end
    end
  end

endmodule

// ===== sim/vdrm_checker.sv =====
// ----------------------------------------------------------------------------
// vdrm_checker
// Watches the request and result channels of the virtqueue descriptor ring
// manager. It keeps its own copy of the free list and ring positions,
// predicts one result per accepted request beat and compares each result
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module vdrm_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  vdrm_req_if                        req,
  vdrm_rsp_if                        rsp,
  input  logic                       cfg_we,
  input  logic [vdrm_pkg::CNT_W-1:0] cfg_wdata,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = vdrm_pkg::IDX_W;
  localparam int CNT_W = vdrm_pkg::CNT_W;
  localparam int MAXD  = vdrm_pkg::MAX_DESCRIPTORS;

  typedef struct packed {
    logic [IDX_W-1:0] alloc_index;
    logic             out_of_descriptors;
    logic [CNT_W-1:0] free_count;
    logic [IDX_W-1:0] avail_position;
    logic [IDX_W-1:0] used_position;
  } op_result_t;

  // Shadow of the queue state that reaches the outputs
  logic [CNT_W-1:0] next_link [MAXD];
  logic [CNT_W-1:0] list_head;
  logic [CNT_W-1:0] free_left;
  logic [CNT_W-1:0] q_size;
  logic [IDX_W-1:0] avail_pos;
  logic [IDX_W-1:0] used_pos;

  op_result_t queued_results [$];

  // Size write: clamp, rechain 0..size-1, clear ring positions
  function automatic void rebuild_queue(input logic [CNT_W-1:0] req_size);
    logic [CNT_W-1:0] sz;
    sz = req_size;
    if (sz == '0) sz = CNT_W'(1);
    if (sz > CNT_W'(MAXD)) sz = CNT_W'(MAXD);
    q_size = sz;
    for (int i = 0; i < MAXD; i++) next_link[i] = CNT_W'(i + 1);
    next_link[sz - 1'b1] = sz;
    list_head = '0;
    free_left = sz;
    avail_pos = '0;
    used_pos  = '0;
  endfunction

  // Pointers past the table land on row 0
  function automatic logic [IDX_W-1:0] table_row(input logic [CNT_W-1:0] ptr);
    return (ptr < CNT_W'(MAXD)) ? ptr[IDX_W-1:0] : '0;
  endfunction

  function automatic logic [IDX_W-1:0] advance_pos(input logic [IDX_W-1:0] pos);
    logic [CNT_W-1:0] n;
    n = {1'b0, pos} + CNT_W'(1);
    return (n >= q_size) ? '0 : n[IDX_W-1:0];
  endfunction

  // Apply one operation to the shadow state and return what it reports
  function automatic op_result_t run_op(input vdrm_pkg::kind_t k,
                                        input logic [IDX_W-1:0] idx);
    op_result_t r;
    logic [IDX_W-1:0] row;
    r = '0;
    case (k)
      vdrm_pkg::KIND_ALLOC: begin
        if (free_left == '0) begin
          r.out_of_descriptors = 1'b1;
        end else begin
          row = table_row(list_head);
          r.alloc_index = row;
          list_head = next_link[row];
          free_left = free_left - 1'b1;
        end
      end
      vdrm_pkg::KIND_FREE: begin
        // out-of-range ids and a full list are ignored; double free is taken
        if ({1'b0, idx} < q_size && free_left < q_size) begin
          next_link[idx] = list_head;
          list_head = {1'b0, idx};
          free_left = free_left + 1'b1;
        end
      end
      vdrm_pkg::KIND_ADD_AVAIL: avail_pos = advance_pos(avail_pos);
      default:                  used_pos  = advance_pos(used_pos);
    endcase
    r.free_count     = free_left;
    r.avail_position = avail_pos;
    r.used_position  = used_pos;
    return r;
  endfunction

  // Predict on request beats, compare on result beats
  always @(posedge clk) begin : track
    op_result_t got;
    op_result_t want;
    if (!rst_n) begin
      rebuild_queue(CNT_W'(MAXD));
      queued_results.delete();
      errors  = 0;
      pending <= 0;
    end else begin
      if (cfg_we) rebuild_queue(cfg_wdata);
      if (req.valid && req.ready) queued_results.push_back(run_op(req.kind, req.desc_index));
      if (rsp.valid && rsp.ready) begin
        got.alloc_index        = rsp.alloc_index;
        got.out_of_descriptors = rsp.out_of_descriptors;
        got.free_count         = rsp.free_count;
        got.avail_position     = rsp.avail_position;
        got.used_position      = rsp.used_position;
        if (queued_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: result beat with nothing outstanding: idx=%0d oob=%0d free=%0d",
                     $realtime, got.alloc_index, got.out_of_descriptors, got.free_count);
          errors++;
        end else begin
          want = queued_results.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("%0t: mismatch exp idx=%0d oob=%0d free=%0d avail=%0d used=%0d",
                       $realtime, want.alloc_index, want.out_of_descriptors,
                       want.free_count, want.avail_position, want.used_position);
              $display("%0t:          got idx=%0d oob=%0d free=%0d avail=%0d used=%0d",
                       $realtime, got.alloc_index, got.out_of_descriptors,
                       got.free_count, got.avail_position, got.used_position);
            end
            errors++;
          end
        end
      end
      pending <= queued_results.size();
    end
  end

endmodule

// ===== sim/tb_virtqueue_descriptor_ring_manager_top.sv =====
// ----------------------------------------------------------------------------
// tb_virtqueue_descriptor_ring_manager_top
// Drives alloc, free and ring operations into the descriptor ring manager
// over a range of queue sizes, with random gaps and result stalls. The
// checker beside the block predicts and compares; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_virtqueue_descriptor_ring_manager_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W       = vdrm_pkg::IDX_W;
  localparam int CNT_W       = vdrm_pkg::CNT_W;
  localparam int DATA_W      = vdrm_pkg::DATA_W;
  localparam int MAXD        = vdrm_pkg::MAX_DESCRIPTORS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 12;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  int               mon_errors;
  int               mon_pending;
  int               cycle_count;
  bit               idle_on;
  int               live_size;

  vdrm_req_if in_ch ();
  vdrm_rsp_if out_ch ();

  virtqueue_descriptor_ring_manager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  vdrm_checker mon (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_ch),
    .rsp       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (mon_errors),
    .pending   (mon_pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall before taking each beat
  initial begin : rsp_sink
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      n = idle_on ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // One request beat, after a random gap
  task automatic send_op(input vdrm_pkg::kind_t k, input logic [DATA_W-1:0] a,
                         input logic [DATA_W-1:0] l, input logic [IDX_W-1:0] d);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.buf_addr   <= a;
    in_ch.buf_len    <= l;
    in_ch.desc_index <= d;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every result beat has been taken
  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (mon_pending != 0);
  endtask

  task automatic program_size(input int unsigned v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_size = (v == 0) ? 1 : ((v > MAXD) ? MAXD : v);
  endtask

  // Random beat; alloc-heavy mode drives the list to empty
  task automatic send_random(input bit alloc_heavy);
    int r;
    logic [IDX_W-1:0] d;
    vdrm_pkg::kind_t k;
    r = $urandom_range(0, 99);
    if (alloc_heavy) begin
      if (r < 90) k = vdrm_pkg::KIND_ALLOC;
      else if (r < 94) k = vdrm_pkg::KIND_FREE;
      else if (r < 97) k = vdrm_pkg::KIND_ADD_AVAIL;
      else k = vdrm_pkg::KIND_ADD_USED;
    end else begin
      if (r < 45) k = vdrm_pkg::KIND_ALLOC;
      else if (r < 80) k = vdrm_pkg::KIND_FREE;
      else if (r < 90) k = vdrm_pkg::KIND_ADD_AVAIL;
      else k = vdrm_pkg::KIND_ADD_USED;
    end
    // frees mostly name a live descriptor, some fall outside the queue
    if (k == vdrm_pkg::KIND_FREE && $urandom_range(0, 99) < 85)
      d = IDX_W'($urandom_range(0, live_size - 1));
    else
      d = IDX_W'($urandom_range(0, 255));
    send_op(k, $urandom, $urandom, d);
  endtask

  initial begin : stim
    int unsigned sizes [PHASES];
    int n_items;
    in_ch.valid      = 1'b0;
    in_ch.kind       = vdrm_pkg::KIND_ALLOC;
    in_ch.buf_addr   = '0;
    in_ch.buf_len    = '0;
    in_ch.desc_index = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    idle_on          = 1'b1;
    live_size        = MAXD;
    rst_n            = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset size, extreme fields, double free, full-list free
    send_op(vdrm_pkg::KIND_ALLOC, '1, '1, '0);
    send_op(vdrm_pkg::KIND_ALLOC, '0, '0, '1);
    send_op(vdrm_pkg::KIND_FREE, '0, '0, 8'd255);
    send_op(vdrm_pkg::KIND_FREE, '1, '1, 8'd255);
    send_op(vdrm_pkg::KIND_FREE, '0, '0, 8'd1);
    send_op(vdrm_pkg::KIND_FREE, '0, '0, 8'd0);
    send_op(vdrm_pkg::KIND_ADD_AVAIL, '1, '1, 8'd255);
    send_op(vdrm_pkg::KIND_ADD_AVAIL, '0, '0, 8'd0);
    send_op(vdrm_pkg::KIND_ADD_USED, '1, '1, 8'd255);
    send_op(vdrm_pkg::KIND_ADD_USED, '0, '0, 8'd0);
    send_op(vdrm_pkg::KIND_ALLOC, 32'h1234_5678, 32'h8765_4321, '0);

    // Size zero counts as one: empty list, free above size, ring wrap at one
    program_size(0);
    send_op(vdrm_pkg::KIND_ALLOC, '1, '0, '0);
    send_op(vdrm_pkg::KIND_ALLOC, '0, '1, '0);
    send_op(vdrm_pkg::KIND_FREE, '0, '0, 8'd1);
    send_op(vdrm_pkg::KIND_FREE, '0, '0, 8'd0);
    send_op(vdrm_pkg::KIND_FREE, '0, '0, 8'd0);
    send_op(vdrm_pkg::KIND_ADD_AVAIL, '0, '0, 8'd7);
    send_op(vdrm_pkg::KIND_ADD_AVAIL, '0, '0, 8'd9);
    send_op(vdrm_pkg::KIND_ADD_USED, '0, '1, 8'd3);
    send_op(vdrm_pkg::KIND_ADD_USED, '0, '0, 8'd4);

    // Oversized write clamps to the table depth
    program_size(511);
    send_op(vdrm_pkg::KIND_ALLOC, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0);
    send_op(vdrm_pkg::KIND_ADD_AVAIL, '0, '0, 8'hAA);

    // Random phases over several sizes
    sizes = '{2, 4, 256, 1, 3, 8, 16, 128, 511, 64, 0, 0};
    sizes[10] = $urandom_range(0, 511);
    sizes[11] = $urandom_range(0, 511);
    for (int p = 0; p < PHASES; p++) begin
      program_size(sizes[p]);
      idle_on = (p % 3) != 0;
      n_items = (p == 2) ? 340 : 50;
      for (int i = 0; i < n_items; i++) begin
        // hold off until the block has caught up
        if (i == 25 && p % 4 == 1) drain();
        send_random(p == 2);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mon_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
